/* rtl/exyz_pkg.sv */
package exyz_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_WIDTH = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;                 // CORDIC datapath, Q1.30 plus guard
  localparam int ZW = 33;                 // phase accumulator
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam int VW = 36;                 // intermediate vector width
  localparam int SW = 18;                 // Q1.16 sin/cos, range +-65536

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cord_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051D;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2E;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
        5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
        5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  // floor((v + 2^13) / 2^14) clamped to +-1.0 in Q1.16
  function automatic logic signed [SW-1:0] to_q16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      r = (v + CW'(8192)) >>> 14;
      if (r > CW'(65536)) r = CW'(65536);
      if (r < -CW'(65536)) r = -CW'(65536);
      return r[SW-1:0];
    end
  endfunction

endpackage

/* rtl/exyz_cordic_cell.sv */
module exyz_cordic_cell import exyz_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  cord_t      d_i,
  output cord_t      q_o
);
  cord_t r_q;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  // step_i is tied to a constant per cell, so the shifts fold to wiring
  assign dx = d_i.y >>> step_i;
  assign dy = d_i.x >>> step_i;
  assign at = $signed({1'b0, atan_turn(step_i)});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q.flip <= d_i.flip;
      if (!d_i.z[ZW-1]) begin
        r_q.x <= d_i.x - dx;
        r_q.y <= d_i.y + dy;
        r_q.z <= d_i.z - at;
      end else begin
        r_q.x <= d_i.x + dx;
        r_q.y <= d_i.y - dy;
        r_q.z <= d_i.z + at;
      end
    end
  end
  assign q_o = r_q;
endmodule

/* rtl/exyz_mix.sv */
// floor((a*c + b*s + 2^15) / 2^16), registered
module exyz_mix import exyz_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [VW-1:0] a_i,
  input  logic signed [SW-1:0] c_i,
  input  logic signed [VW-1:0] b_i,
  input  logic signed [SW-1:0] s_i,
  output logic signed [VW-1:0] r_o
);
  logic signed [VW+SW:0] sum;
  assign sum = (VW+SW+1)'(a_i * c_i) + (VW+SW+1)'(b_i * s_i) + (VW+SW+1)'(32768);
  always_ff @(posedge clk_i) begin
    if (en_i) r_o <= VW'(sum >>> 16);
  end
endmodule

/* rtl/euler_xyz_vector_rotation.sv */
// Euler x-y-z rotation of a Q15.16 vector, row vector times Rx*Ry*Rz.
// Input request: vec_x/y/z_i and turn_x/y/z_i on in_valid_i/in_ready_o.
// Result request: rot_x/y/z_o and clipped_o on out_valid_o/out_ready_i.
// Sine/cosine come from three 24-cell CORDIC chains run side by side; the
// vector waits in a matching delay line, then passes one stage per axis.
// Pipeline: 24 CORDIC cells, 1 scaling stage, 3 mix stages and 1 output
// register between acceptance and out_valid_o.
// One request per cycle when not stalled; the chain has no loop back.
// When the receiver stalls, the whole pipeline holds (a global enable), so
// in_ready_o follows out_ready_i or an empty output slot; no data is lost.
// Reset clears the valid bits only; payload registers are not reset.
module euler_xyz_vector_rotation import exyz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [15:0] turn_x_i,
  input  logic [15:0] turn_y_i,
  input  logic [15:0] turn_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rot_x_o,
  output logic [31:0] rot_y_o,
  output logic [31:0] rot_z_o,
  output logic        clipped_o
);
  localparam int Depth = CORDIC_STEPS + 5;

  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // angle front end and CORDIC chains
  logic [ANGLE_BITS-1:0] turn [3];
  assign turn[0] = turn_x_i[ANGLE_BITS-1:0];
  assign turn[1] = turn_y_i[ANGLE_BITS-1:0];
  assign turn[2] = turn_z_i[ANGLE_BITS-1:0];

  cord_t chain [3][CORDIC_STEPS+1];
  logic signed [SW-1:0] sn_q [3];
  logic signed [SW-1:0] cs_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [31:0] p, pf;
    logic flip;
    assign p = {turn[a], (32-ANGLE_BITS)'(0)};
    assign flip = p[31] ^ p[30];
    assign pf = flip ? (p ^ 32'h80000000) : p;
    assign chain[a][0].x = CORDIC_GAIN;
    assign chain[a][0].y = '0;
    assign chain[a][0].z = ZW'($signed(pf));
    assign chain[a][0].flip = flip;
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      exyz_cordic_cell u_cell (
        .clk_i(clk_i), .en_i(en), .step_i(5'(k)), .d_i(chain[a][k]), .q_o(chain[a][k+1])
      );
    end
    logic signed [SW-1:0] c0, s0;
    assign c0 = to_q16(chain[a][CORDIC_STEPS].x);
    assign s0 = to_q16(chain[a][CORDIC_STEPS].y);
    always_ff @(posedge clk_i) begin
      if (en) begin
        cs_q[a] <= chain[a][CORDIC_STEPS].flip ? -c0 : c0;
        sn_q[a] <= chain[a][CORDIC_STEPS].flip ? -s0 : s0;
      end
    end
  end

  // vector delay line matching the CORDIC chain + scaling stage
  logic signed [VW-1:0] dx_q [CORDIC_STEPS+1];
  logic signed [VW-1:0] dy_q [CORDIC_STEPS+1];
  logic signed [VW-1:0] dz_q [CORDIC_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0] <= VW'($signed(vec_x_i[COORD_WIDTH-1:0]));
      dy_q[0] <= VW'($signed(vec_y_i[COORD_WIDTH-1:0]));
      dz_q[0] <= VW'($signed(vec_z_i[COORD_WIDTH-1:0]));
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        dx_q[i] <= dx_q[i-1];
        dy_q[i] <= dy_q[i-1];
        dz_q[i] <= dz_q[i-1];
      end
    end
  end

  // angle terms delayed for stages 2 and 3
  logic signed [SW-1:0] sy_q, cy_q, sz_q [2], cz_q [2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sy_q <= sn_q[1]; cy_q <= cs_q[1];
      sz_q[0] <= sn_q[2]; cz_q[0] <= cs_q[2];
      sz_q[1] <= sz_q[0]; cz_q[1] <= cz_q[0];
    end
  end

  // stage Rx
  logic signed [VW-1:0] x1_q, y1, z1;
  always_ff @(posedge clk_i) if (en) x1_q <= dx_q[CORDIC_STEPS];
  exyz_mix u_rx_y (.clk_i, .en_i(en), .a_i(dy_q[CORDIC_STEPS]), .c_i(cs_q[0]),
                   .b_i(dz_q[CORDIC_STEPS]), .s_i(sn_q[0]), .r_o(y1));
  exyz_mix u_rx_z (.clk_i, .en_i(en), .a_i(dy_q[CORDIC_STEPS]), .c_i(-sn_q[0]),
                   .b_i(dz_q[CORDIC_STEPS]), .s_i(cs_q[0]), .r_o(z1));
  // stage Ry
  logic signed [VW-1:0] x2, y2_q, z2;
  always_ff @(posedge clk_i) if (en) y2_q <= y1;
  exyz_mix u_ry_x (.clk_i, .en_i(en), .a_i(x1_q), .c_i(cy_q),
                   .b_i(z1), .s_i(-sy_q), .r_o(x2));
  exyz_mix u_ry_z (.clk_i, .en_i(en), .a_i(x1_q), .c_i(sy_q),
                   .b_i(z1), .s_i(cy_q), .r_o(z2));
  // stage Rz
  logic signed [VW-1:0] x3, y3, z3_q;
  always_ff @(posedge clk_i) if (en) z3_q <= z2;
  exyz_mix u_rz_x (.clk_i, .en_i(en), .a_i(x2), .c_i(cz_q[1]),
                   .b_i(y2_q), .s_i(sz_q[1]), .r_o(x3));
  exyz_mix u_rz_y (.clk_i, .en_i(en), .a_i(x2), .c_i(-sz_q[1]),
                   .b_i(y2_q), .s_i(cz_q[1]), .r_o(y3));

  // saturation
  localparam logic signed [VW-1:0] Hi = VW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [VW-1:0] Lo = -Hi - VW'(1);
  logic signed [VW-1:0] v [3];
  logic [COORD_WIDTH-1:0] sat [3];
  logic [2:0] clp;
  assign v[0] = x3; assign v[1] = y3; assign v[2] = z3_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clp[k] = 1'b1;
      if (v[k] > Hi) sat[k] = Hi[COORD_WIDTH-1:0];
      else if (v[k] < Lo) sat[k] = Lo[COORD_WIDTH-1:0];
      else begin
        sat[k] = v[k][COORD_WIDTH-1:0];
        clp[k] = 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_x_o <= 32'($signed(sat[0]));
      rot_y_o <= 32'($signed(sat[1]));
      rot_z_o <= 32'($signed(sat[2]));
      clipped_o <= |clp;
    end
  end
endmodule
